[src/imtv_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// imtv_pkg
// Shared types and constants of the address text validator: error codes,
// separator and limit constants, the per-string state and the verdict.
// ============================================================================
package imtv_pkg;

    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_BAD_CHAR  = 3'd1,
        ERR_SEP_COUNT = 3'd2,
        ERR_EMPTY     = 3'd3,
        ERR_OVER      = 3'd4,
        ERR_MAC_LEN   = 3'd5
    } err_t;

    localparam logic [8:0] OCTET_MAX     = 9'd255;
    localparam logic [8:0] GROUP_SAT     = 9'd256;
    localparam logic [2:0] IP_SEPS       = 3'd3;
    localparam logic [2:0] MAC_SEPS      = 3'd5;
    localparam logic [2:0] MAC_GROUP_LEN = 3'd2;
    localparam logic [2:0] COUNT_MAX     = 3'd7;

    localparam logic [7:0] CHAR_DOT      = 8'h2E;
    localparam logic [7:0] CHAR_COLON    = 8'h3A;
    localparam logic [7:0] CHAR_DASH     = 8'h2D;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam logic [7:0] CHAR_LOW_A    = 8'h61;
    localparam logic [7:0] CHAR_LOW_F    = 8'h66;
    localparam logic [7:0] CHAR_UP_A     = 8'h41;
    localparam logic [7:0] CHAR_UP_F     = 8'h46;

    typedef struct packed {
        logic       at_start;
        logic       kind_is_mac;
        logic [2:0] sep_count;
        logic [2:0] group_len;
        logic [8:0] group_val;
        err_t       first_error;
    } state_t;

    typedef struct packed {
        logic valid;
        err_t error;
    } verdict_t;

endpackage
`default_nettype wire

[src/ip_mac_text_validator.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ip_mac_text_validator
// Checks IPv4 dotted or MAC address text streamed one character per request.
// The block takes one character every cycle unless the input is stalled.
// Each accepted character lands in an input register; a state update
// (counters, group value, first error) then consumes it, and the verdict
// of a character marked last is written to the result register, so a
// result passes the input register and then the result register. The
// address kind is taken from operation at the first character of each
// string. A waiting result stalls the input only while a character marked
// last sits in the input register.
// ============================================================================
module ip_mac_text_validator (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire        s_operation,
    input  wire [7:0]  s_character,
    input  wire        s_last,
    output logic       m_valid,
    input  wire        m_ready,
    output logic       m_valid_res,
    output logic [2:0] m_error_code
);

    logic               in_valid_reg;
    logic               in_operation_reg;
    logic [7:0]         in_character_reg;
    logic               in_last_reg;
    imtv_pkg::state_t   state_reg;
    imtv_pkg::state_t   state_next;
    imtv_pkg::verdict_t verdict;
    logic               m_valid_reg;
    logic               m_valid_res_reg;
    imtv_pkg::err_t     m_error_reg;
    logic               out_free;
    logic               advance;

    imtv_step u_step (
        .state_i     (state_reg),
        .operation_i (in_operation_reg),
        .character_i (in_character_reg),
        .last_i      (in_last_reg),
        .state_o     (state_next),
        .verdict_o   (verdict)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_last_reg || out_free);
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_operation_reg <= s_operation;
            in_character_reg <= s_character;
            in_last_reg      <= s_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.at_start    <= 1'b1;
            state_reg.kind_is_mac <= 1'b0;
            state_reg.sep_count   <= 3'd0;
            state_reg.group_len   <= 3'd0;
            state_reg.group_val   <= 9'd0;
            state_reg.first_error <= imtv_pkg::ERR_OK;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && verdict.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && verdict.valid) begin
            m_valid_res_reg <= (verdict.error == imtv_pkg::ERR_OK);
            m_error_reg     <= verdict.error;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_valid_res  = m_valid_res_reg;
    assign m_error_code = m_error_reg;

    a_res_match: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_valid_res_reg == (m_error_reg == imtv_pkg::ERR_OK)))
        else $error("verdict flag disagrees with error code");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_error_reg <= imtv_pkg::ERR_MAC_LEN))
        else $error("error code out of range");

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> state_reg.at_start)
        else $error("no re-arm after last character");

    a_group_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.group_val <= imtv_pkg::GROUP_SAT)
        else $error("group value above saturation");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !(advance && in_last_reg))
        else $error("result overwritten while waiting");

endmodule
`default_nettype wire

[src/imtv_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// imtv_step
// Next-state and verdict logic for one character: classify the character,
// update counters and the group value, keep the first error, and on the last
// character close the final group and check the separator count.
// ============================================================================
module imtv_step (
    input  wire imtv_pkg::state_t   state_i,
    input  wire                     operation_i,
    input  wire [7:0]               character_i,
    input  wire                     last_i,
    output imtv_pkg::state_t        state_o,
    output imtv_pkg::verdict_t      verdict_o
);

    function automatic imtv_pkg::err_t close_err(
        input imtv_pkg::err_t cur,
        input logic [2:0]     len,
        input logic           is_mac
    );
        imtv_pkg::err_t e;
        e = cur;
        if (cur == imtv_pkg::ERR_OK) begin
            if (len == 3'd0) begin
                e = imtv_pkg::ERR_EMPTY;
            end else if (is_mac && len != imtv_pkg::MAC_GROUP_LEN) begin
                e = imtv_pkg::ERR_MAC_LEN;
            end
        end
        return e;
    endfunction

    imtv_pkg::state_t st;
    imtv_pkg::err_t   err;
    logic             is_sep;
    logic             is_dig;
    logic             is_hx;
    logic             char_ok;
    logic [11:0]      acc;

    always_comb begin
        st  = state_i;
        err = imtv_pkg::ERR_OK;

        // latch the kind and clear the string state on the first character
        if (st.at_start) begin
            st.kind_is_mac = operation_i;
            st.sep_count   = 3'd0;
            st.group_len   = 3'd0;
            st.group_val   = 9'd0;
            st.first_error = imtv_pkg::ERR_OK;
            st.at_start    = 1'b0;
        end

        is_sep  = st.kind_is_mac
                ? (character_i == imtv_pkg::CHAR_COLON || character_i == imtv_pkg::CHAR_DASH)
                : (character_i == imtv_pkg::CHAR_DOT);
        is_dig  = (character_i >= imtv_pkg::CHAR_ZERO) && (character_i <= imtv_pkg::CHAR_NINE);
        is_hx   = is_dig
                || ((character_i >= imtv_pkg::CHAR_LOW_A) && (character_i <= imtv_pkg::CHAR_LOW_F))
                || ((character_i >= imtv_pkg::CHAR_UP_A) && (character_i <= imtv_pkg::CHAR_UP_F));
        char_ok = st.kind_is_mac ? is_hx : is_dig;
        acc     = {3'b000, st.group_val} * 12'd10 + {8'h00, character_i[3:0]};

        if (st.first_error == imtv_pkg::ERR_OK) begin
            if (is_sep) begin
                st.first_error = close_err(st.first_error, st.group_len, st.kind_is_mac);
                if (st.sep_count != imtv_pkg::COUNT_MAX) begin
                    st.sep_count = st.sep_count + 3'd1;
                end
                st.group_len = 3'd0;
                st.group_val = 9'd0;
            end else if (!char_ok) begin
                st.first_error = imtv_pkg::ERR_BAD_CHAR;
            end else begin
                if (st.group_len != imtv_pkg::COUNT_MAX) begin
                    st.group_len = st.group_len + 3'd1;
                end
                if (!st.kind_is_mac) begin
                    if (acc > {3'b000, imtv_pkg::OCTET_MAX}) begin
                        st.group_val   = imtv_pkg::GROUP_SAT;
                        st.first_error = imtv_pkg::ERR_OVER;
                    end else begin
                        st.group_val = acc[8:0];
                    end
                end
            end
        end

        if (last_i) begin
            err = close_err(st.first_error, st.group_len, st.kind_is_mac);
            if (err == imtv_pkg::ERR_OK &&
                st.sep_count != (st.kind_is_mac ? imtv_pkg::MAC_SEPS : imtv_pkg::IP_SEPS)) begin
                err = imtv_pkg::ERR_SEP_COUNT;
            end
            // re-arm for the next string
            st.at_start    = 1'b1;
            st.sep_count   = 3'd0;
            st.group_len   = 3'd0;
            st.group_val   = 9'd0;
            st.first_error = imtv_pkg::ERR_OK;
        end

        state_o         = st;
        verdict_o.valid = last_i;
        verdict_o.error = err;
    end

endmodule
`default_nettype wire
